### design/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg: shared types and constants for the edit distance engine
// Sizes of the symbol stores and the distance row, and the command codes.
// ----------------------------------------------------------------------------
package edd_pkg;

   // longest sequence that the stores hold
   localparam int MAX_LEN = 64;
   // index into a store of MAX_LEN entries
   localparam int IDX_W   = $clog2(MAX_LEN);
   // lengths and distances run from 0 to MAX_LEN
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 32;
   localparam int DIST_W  = 7;

   typedef logic [1:0]        cmd_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [DIST_W-1:0] dist_type;

   // command codes
   localparam cmd_type CMD_CLEAR    = 2'd0;
   localparam cmd_type CMD_APPEND_A = 2'd1;
   localparam cmd_type CMD_APPEND_B = 2'd2;
   localparam cmd_type CMD_COMPUTE  = 2'd3;

   localparam len_type LEN_FULL = len_type'(MAX_LEN);

endpackage

### design/edit_distance_engine_top.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_top: unit-cost Levenshtein distance engine
// Holds two symbol sequences in memories and walks the distance table one
// cell per cycle within a row, over a single row memory.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+-----------
//  command  | start, busy, req_cmd, req_symbol       | in, busy out
//  result   | rsp_valid, rsp_distance, rsp_overflow  | out
//
//  clear and append leave busy low. compute with both sequences non-empty
//  walks the table row by row: each row opens with a state that reads the
//  A symbol and the first row entry, then steps through its cells, the row
//  memory reading the next entry while it writes the current one; the
//  result strobes in the first cycle with busy low.
//  an empty sequence gives the result next cycle.
//  reset is synchronous and empties both sequences; the receiver cannot stall.
// ----------------------------------------------------------------------------
module edit_distance_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  edd_pkg::cmd_type              req_cmd,
   input  logic signed [edd_pkg::SYM_W-1:0] req_symbol,
   output logic                          rsp_valid,
   output edd_pkg::dist_type             rsp_distance,
   output logic                          rsp_overflow
);
   import edd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROW  = 2'd1;
   localparam logic [1:0] ST_CELL = 2'd2;

   // symbol stores and distance row
   logic [SYM_W-1:0] seq_a [MAX_LEN];
   logic [SYM_W-1:0] seq_b [MAX_LEN];
   len_type          dp_row [MAX_LEN];

   logic [1:0]       state_ff, state_in;
   len_type          len_a_ff, len_a_in;
   len_type          len_b_ff, len_b_in;
   logic             ovf_ff, ovf_in;
   len_type          i_ff, i_in;
   len_type          j_ff, j_in;
   len_type          left_ff, left_in;
   len_type          diag_ff, diag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dist_type         rsp_dist_ff, rsp_dist_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [SYM_W-1:0] a_rd_ff;
   logic [SYM_W-1:0] b_rd_ff;
   len_type          up_rd_ff;

   logic             accept;
   logic             wr_a, wr_b, rd_a, rd_row, wr_row;
   idx_type          rd_idx;
   len_type          up, up_p1, left_p1, diag_c, best;
   logic             cost;

   assign accept = start && (state_ff == ST_IDLE);

   // cell arithmetic: first row above is 0..len_b, not stored
   always_comb begin
      up      = (i_ff == len_type'(1)) ? j_ff : up_rd_ff;
      cost    = (a_rd_ff != b_rd_ff);
      up_p1   = up + len_type'(1);
      left_p1 = left_ff + len_type'(1);
      diag_c  = diag_ff + len_type'(cost);
      best    = (up_p1 < left_p1) ? up_p1 : left_p1;
      if (diag_c < best) begin
         best = diag_c;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      rsp_valid_in = 1'b0;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      rd_a         = 1'b0;
      rd_row       = 1'b0;
      wr_row       = 1'b0;
      rd_idx       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     len_a_in = '0;
                     len_b_in = '0;
                     ovf_in   = 1'b0;
                  end
                  CMD_APPEND_A: begin
                     if (len_a_ff == LEN_FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_a     = 1'b1;
                        len_a_in = len_a_ff + len_type'(1);
                     end
                  end
                  CMD_APPEND_B: begin
                     if (len_b_ff == LEN_FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_b     = 1'b1;
                        len_b_in = len_b_ff + len_type'(1);
                     end
                  end
                  CMD_COMPUTE: begin
                     if (len_a_ff == '0 || len_b_ff == '0) begin
                        // empty side: distance is the other length
                        rsp_valid_in = 1'b1;
                        rsp_dist_in  = dist_type'(len_a_ff | len_b_ff);
                        rsp_ovf_in   = ovf_ff;
                     end else begin
                        i_in     = len_type'(1);
                        state_in = ST_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            // fetch the A symbol and the first entries of the row
            rd_a     = 1'b1;
            rd_row   = 1'b1;
            rd_idx   = '0;
            j_in     = len_type'(1);
            left_in  = i_ff;
            diag_in  = i_ff - len_type'(1);
            state_in = ST_CELL;
         end
         ST_CELL: begin
            wr_row  = 1'b1;
            left_in = best;
            diag_in = up;
            if (j_ff == len_b_ff) begin
               if (i_ff == len_a_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_dist_in  = dist_type'(best);
                  rsp_ovf_in   = ovf_ff;
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_ff + len_type'(1);
                  state_in = ST_ROW;
               end
            end else begin
               // next cell's entry sits at index j
               rd_row = 1'b1;
               rd_idx = j_ff[IDX_W-1:0];
               j_in   = j_ff + len_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // sequence A store
   always_ff @(posedge clock) begin
      if (wr_a) begin
         seq_a[len_a_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (rd_a) begin
         a_rd_ff <= seq_a[i_ff[IDX_W-1:0] - idx_type'(1)];
      end
   end

   // sequence B store
   always_ff @(posedge clock) begin
      if (wr_b) begin
         seq_b[len_b_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (rd_row) begin
         b_rd_ff <= seq_b[rd_idx];
      end
   end

   // distance row, entry j kept at index j-1; write j never meets read j+1
   always_ff @(posedge clock) begin
      if (wr_row) begin
         dp_row[j_ff[IDX_W-1:0] - idx_type'(1)] <= best;
      end
      if (rd_row) begin
         up_rd_ff <= dp_row[rd_idx];
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

### design/edd_checker.sv
// ----------------------------------------------------------------------------
// edd_checker: port-level checks for the edit distance engine
// Watches the command and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module edd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input edd_pkg::cmd_type      req_cmd,
   input logic                  rsp_valid,
   input edd_pkg::dist_type     rsp_distance
);
   import edd_pkg::*;

   // a result word follows a compute word or the end of a table walk
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && !busy && req_cmd == CMD_COMPUTE)))
      else $error("result strobe without a compute");

   // no result while a compute is still walking the table
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // compute either runs or answers at once
   a_compute_acts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_COMPUTE) |=> (busy || rsp_valid))
      else $error("compute word neither started nor answered");

   // clear and append leave busy low and give no result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd != CMD_COMPUTE) |=> (!busy && !rsp_valid))
      else $error("load word caused busy or a result");

   // the distance never exceeds the longest sequence
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= dist_type'(MAX_LEN)))
      else $error("distance out of range");

endmodule

bind edit_distance_engine_top edd_checker u_edd_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_cmd      (req_cmd),
   .rsp_valid    (rsp_valid),
   .rsp_distance (rsp_distance)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the edit distance engine
// Sends clear, append and compute words over the start/busy port. An internal
// sequence model predicts each compute result, and every strobed result is
// checked against the oldest prediction. Directed words and full-store cases
// come first, then random sequences, with idle gaps that vary by phase.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import edd_pkg::*;

   // run length guard and quiet time after the last result
   localparam longint CYCLE_LIMIT  = 1_000_000;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     WORD_TARGET   = 2000;

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] symbol;
      int                 idle_pct;
      bit                 drain;
   } word_type;

   typedef struct packed {
      dist_type distance;
      logic     overflow;
   } result_type;

   logic               clock;
   logic               reset;
   logic               start = 1'b0;
   logic               busy;
   cmd_type            req_cmd = CMD_CLEAR;
   logic signed [31:0] req_symbol = '0;
   logic               rsp_valid;
   dist_type           rsp_distance;
   logic               rsp_overflow;

   word_type   pending_words[$];
   word_type   current_word;
   result_type expected_distances[$];
   int         words_queued = 0;
   int         results_predicted = 0;
   int         results_seen = 0;
   int         mismatches = 0;
   longint     cycle_count = 0;

   // sequence model state
   logic [31:0] a_syms [MAX_LEN];
   logic [31:0] b_syms [MAX_LEN];
   int          a_len = 0;
   int          b_len = 0;
   logic        dropped = 1'b0;

   edit_distance_engine_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // single row walk over the held sequences
   function automatic dist_type levenshtein();
      int row [MAX_LEN + 1];
      int diag;
      int up;
      int cost;
      int best;
      for (int j = 0; j <= b_len; j++) row[j] = j;
      for (int i = 1; i <= a_len; i++) begin
         diag = row[0];
         row[0] = i;
         for (int j = 1; j <= b_len; j++) begin
            up = row[j];
            cost = (a_syms[i-1] == b_syms[j-1]) ? 0 : 1;
            best = up + 1;
            if (row[j-1] + 1 < best) best = row[j-1] + 1;
            if (diag + cost < best) best = diag + cost;
            row[j] = best;
            diag = up;
         end
      end
      return dist_type'(row[b_len]);
   endfunction

   // update the model with an accepted word
   task automatic track_word(input word_type w);
      case (w.cmd)
         CMD_CLEAR: begin
            a_len = 0;
            b_len = 0;
            dropped = 1'b0;
         end
         CMD_APPEND_A: begin
            if (a_len < MAX_LEN) begin
               a_syms[a_len] = w.symbol;
               a_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         CMD_APPEND_B: begin
            if (b_len < MAX_LEN) begin
               b_syms[b_len] = w.symbol;
               b_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         default: begin
            expected_distances.push_back('{distance: levenshtein(), overflow: dropped});
            results_predicted++;
         end
      endcase
   endtask

   function automatic void flag_mismatch(string what);
      if (mismatches < 10) $display("mismatch: %s", what);
      mismatches++;
   endfunction

   // word driver
   always @(posedge clock) begin : drive_words
      bit taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) track_word(current_word);
         if (!start || taken) begin
            if (pending_words.size() != 0
                && !(pending_words[0].drain && results_seen != results_predicted)
                && $urandom_range(99) >= pending_words[0].idle_pct) begin
               current_word = pending_words.pop_front();
               start      <= 1'b1;
               req_cmd    <= current_word.cmd;
               req_symbol <= current_word.symbol;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid) begin
         if (expected_distances.size() == 0) begin
            flag_mismatch($sformatf("unexpected result distance %0d overflow %0b",
                                    rsp_distance, rsp_overflow));
         end else begin
            want = expected_distances.pop_front();
            results_seen <= results_seen + 1;
            if (rsp_distance !== want.distance)
               flag_mismatch($sformatf("distance exp %0d got %0d",
                                       want.distance, rsp_distance));
            if (rsp_overflow !== want.overflow)
               flag_mismatch($sformatf("overflow exp %0b got %0b",
                                       want.overflow, rsp_overflow));
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // queue one word; idle rate and drain pause follow the stimulus phase
   task automatic queue_word(input cmd_type cmd, input logic [31:0] symbol);
      word_type w;
      w.cmd = cmd;
      w.symbol = symbol;
      w.idle_pct = (words_queued < 700) ? 17 : (words_queued < 1400) ? 67 : 0;
      w.drain = (words_queued == 700 || words_queued == 1400);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // symbol from a narrow alphabet around a base, or fully random
   function automatic logic [31:0] pick_symbol(logic [31:0] base, int alpha);
      if (alpha == 0) return $urandom;
      return base + $urandom_range(alpha - 1);
   endfunction

   // one sequence pair, after an optional clear, followed by zero or more compute words
   task automatic queue_sequence(input int na, input int nb, input bit do_clear,
                                 input int computes);
      int          alpha;
      logic [31:0] base;
      int          ia;
      int          ib;
      alpha = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      base = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
      ia = 0;
      ib = 0;
      if (do_clear) queue_word(CMD_CLEAR, $urandom);
      while (ia < na || ib < nb) begin
         if (ib >= nb || (ia < na && $urandom_range(1))) begin
            queue_word(CMD_APPEND_A, pick_symbol(base, alpha));
            ia++;
         end else begin
            queue_word(CMD_APPEND_B, pick_symbol(base, alpha));
            ib++;
         end
      end
      repeat (computes) queue_word(CMD_COMPUTE, $urandom);
   endtask

   // stimulus and end of run
   initial begin
      int r;
      int na;
      int nb;
      reset = 1'b1;

      // directed words: empty sequences, symbol extremes, equal and unequal
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_A, 32'h8000_0000);
      queue_word(CMD_COMPUTE, 32'hFFFF_FFFF);
      queue_word(CMD_APPEND_B, 32'h7FFF_FFFF);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_B, 32'h8000_0000);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_A, 32'h0);
      queue_word(CMD_APPEND_A, 32'hFFFF_FFFF);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_CLEAR, 32'hFFFF_FFFF);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_B, 32'hFFFF_FFFF);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_A, 32'hFFFF_FFFF);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_APPEND_A, 32'h5555_5555);
      queue_word(CMD_APPEND_B, 32'hAAAA_AAAA);
      queue_word(CMD_COMPUTE, 32'h0);
      queue_word(CMD_CLEAR, 32'h0);

      // full stores: drop an append on each side, then clear the flag
      queue_sequence(MAX_LEN, MAX_LEN + 1, 1'b1, 1);
      queue_word(CMD_APPEND_A, $urandom);
      queue_word(CMD_COMPUTE, $urandom);
      queue_word(CMD_CLEAR, $urandom);
      queue_word(CMD_COMPUTE, $urandom);
      queue_sequence(MAX_LEN, 3, 1'b1, 1);

      // random sequences, mostly well formed, some noise and broken ones
      while (words_queued < WORD_TARGET) begin
         r = $urandom_range(99);
         if (r < 8) begin
            repeat ($urandom_range(1, 6))
               queue_word(cmd_type'($urandom_range(3)), $urandom);
         end else begin
            if ($urandom_range(49) == 0) begin
               na = $urandom_range(40, MAX_LEN + 2);
               nb = $urandom_range(0, MAX_LEN + 2);
            end else begin
               na = $urandom_range(0, 8);
               nb = $urandom_range(0, 8);
            end
            queue_sequence(na, nb, r >= 15,
                           (r < 20) ? 0 : ($urandom_range(9) == 0) ? 2 : 1);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for all words taken and all results back
      while (pending_words.size() != 0 || start || results_seen != results_predicted)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_distances.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_distances.size()));
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
design/edd_pkg.sv
design/edit_distance_engine_top.sv
design/edd_checker.sv
tb/tb.sv
